// ===== hdl/siag_pkg.sv =====
`timescale 1ns / 1ps
// siag_pkg: shared widths, codes and types of the strided index address generator
// no dependencies

package siag_pkg;

   localparam int NUM_DIMS       = 3;
   localparam int DEF_MAX_EXTENT = 1024;
   localparam int DEF_MAX_RANK   = 3;

   localparam int KIND_W      = 2;
   localparam int DIM_W       = 2;
   localparam int POS_W       = 10;
   localparam int IDX_W       = 10;
   localparam int ADDR_W      = 28;
   localparam int RANK_W      = 2;
   localparam int EXT_REG_W   = 11;
   localparam int STRIDE_W    = 16;
   localparam int PROD_W      = IDX_W + STRIDE_W;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 64;

   localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NEXT    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RANK     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_0 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_1 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_2 = 3'd6;

   typedef struct packed {
      logic                overrun;
      logic                last;
      logic [NUM_DIMS-1:0] in_use;
   } odo_status_type;

endpackage

// ===== hdl/siag_odometer.sv =====
`timescale 1ns / 1ps
// siag_odometer: row-major position counters with carry, restart and overrun detection
// depends on siag_pkg

module siag_odometer #(
   parameter int MAX_EXTENT = siag_pkg::DEF_MAX_EXTENT,
   parameter int TABLE_DIMS = siag_pkg::NUM_DIMS,
   localparam int CW        = $clog2(MAX_EXTENT)
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   step,
   input  logic                                                   restart,
   input  logic [siag_pkg::RANK_W-1:0]                            rank,
   input  logic [siag_pkg::NUM_DIMS-1:0][siag_pkg::EXT_REG_W-1:0] extent,
   output logic [siag_pkg::NUM_DIMS-1:0][CW-1:0]                  cnt_upd,
   output siag_pkg::odo_status_type                               status
);

   localparam int EXT_W = $clog2(MAX_EXTENT + 1);

   logic [siag_pkg::NUM_DIMS-1:0][CW-1:0] cnt_ff;
   logic                                  started_ff;

   logic [siag_pkg::NUM_DIMS-1:0][EXT_W-1:0] ext_eff;
   logic [siag_pkg::RANK_W-1:0]              rank_eff;
   logic [1:0]                               k;
   logic                                     found;
   logic                                     all_end;

   always_comb begin
      rank_eff = (32'(rank) > TABLE_DIMS) ? siag_pkg::RANK_W'(TABLE_DIMS) : rank;
      found    = 1'b0;
      k        = '0;
      cnt_upd  = cnt_ff;
      all_end  = 1'b1;
      status.in_use = '0;
      for (int d = 0; d < siag_pkg::NUM_DIMS; d++) begin
         if (extent[d] == '0) begin
            ext_eff[d] = EXT_W'(1);
         end else if (32'(extent[d]) > MAX_EXTENT) begin
            ext_eff[d] = EXT_W'(MAX_EXTENT);
         end else begin
            ext_eff[d] = EXT_W'(extent[d]);
         end
         status.in_use[d] = (d < int'(rank_eff));
         // innermost dimension that can still advance
         if (status.in_use[d] && (EXT_W'(cnt_ff[d]) + EXT_W'(1) < ext_eff[d])) begin
            found = 1'b1;
            k     = 2'(d);
         end
      end
      if (started_ff && found) begin
         for (int d = 0; d < siag_pkg::NUM_DIMS; d++) begin
            if (status.in_use[d]) begin
               if (d == int'(k)) begin
                  cnt_upd[d] = cnt_ff[d] + CW'(1);
               end else if (d > int'(k)) begin
                  cnt_upd[d] = '0;
               end
            end
         end
      end
      for (int d = 0; d < siag_pkg::NUM_DIMS; d++) begin
         if (status.in_use[d] && (EXT_W'(cnt_upd[d]) + EXT_W'(1) < ext_eff[d])) begin
            all_end = 1'b0;
         end
      end
      status.overrun = started_ff && !found;
      status.last    = !status.overrun && all_end;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         cnt_ff     <= '0;
         started_ff <= 1'b0;
      end else if (step && !status.overrun) begin
         cnt_ff     <= cnt_upd;
         started_ff <= 1'b1;
      end
   end

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      restart |=> !started_ff && cnt_ff == '0)
      else $error("restart did not clear the odometer");

   a_overrun_holds: assert property (@(posedge clock) disable iff (reset)
      step && !restart && status.overrun |=> cnt_ff == $past(cnt_ff) && started_ff)
      else $error("overrun changed the counters");

   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      step && !restart |=> started_ff)
      else $error("next request did not start the iteration");

endmodule

// ===== hdl/strided_index_address_generator.sv =====
`timescale 1ns / 1ps
// strided_index_address_generator: top level, remap tables, multiply-add pipeline, csr block
// depends on siag_pkg and siag_odometer
//
// usage:
//   req channel: tuser carries the request kind (load remap entry, restart, next address);
//   tdata carries dim, position and index value for loads. loads and restarts give no
//   response, every next request gives exactly one response.
//   rsp channel: tdata holds address and the three remapped coordinates, tlast marks the
//   final position of the iteration, tuser flags a next request past the final position.
//   csr channel: writes rank, extents and strides by index; always ready, write only
//   while no request is in flight.
// pipeline: a next request passes the table read, product and sum registers before it is
// valid on rsp; one request can be taken every cycle while rsp is not stalled.
// reset: csr registers return to rank 0, extent 1, stride 0, counters clear; remap
// table contents stay undefined until loaded.
// stall: a stalled rsp keeps its data; the three stages keep filling, and req_tready
// drops only once every stage holds a response.

module strided_index_address_generator #(
   parameter int MAX_EXTENT = siag_pkg::DEF_MAX_EXTENT,
   parameter int MAX_RANK   = siag_pkg::DEF_MAX_RANK
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // dim [1:0], position [11:2], index_value [21:12], zero fill
   input  logic [siag_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // kind
   input  logic [siag_pkg::KIND_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // address [27:0], coord_0 [37:28], coord_1 [47:38], coord_2 [57:48], zero fill
   output logic [siag_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   // overrun
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [siag_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [siag_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int NUM_DIMS   = siag_pkg::NUM_DIMS;
   localparam int TABLE_DIMS = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS;
   localparam int CW         = $clog2(MAX_EXTENT);
   localparam int IDX_W      = siag_pkg::IDX_W;
   localparam int PROD_W     = siag_pkg::PROD_W;
   localparam int ADDR_W     = siag_pkg::ADDR_W;

   // csr registers
   logic [siag_pkg::RANK_W-1:0]                   rank_ff;
   logic [NUM_DIMS-1:0][siag_pkg::EXT_REG_W-1:0]  extent_ff;
   logic [NUM_DIMS-1:0][siag_pkg::STRIDE_W-1:0]   stride_ff;

   // request fields
   logic [siag_pkg::DIM_W-1:0] req_dim;
   logic [siag_pkg::POS_W-1:0] req_position;
   logic [IDX_W-1:0]           req_index_value;
   logic                       req_acc;
   logic                       do_load;
   logic                       do_next;
   logic                       do_restart;
   logic                       pos_ok;

   logic [NUM_DIMS-1:0][CW-1:0] cnt_upd;
   siag_pkg::odo_status_type    odo_status;

   // stage 1: table read
   logic                     s1_valid_ff;
   siag_pkg::odo_status_type s1_status_ff;
   logic [IDX_W-1:0]         rd_ff [NUM_DIMS];

   // stage 2: products
   logic                     s2_valid_ff;
   logic                     s2_last_ff;
   logic                     s2_overrun_ff;
   logic [IDX_W-1:0]         coord_ff [NUM_DIMS];
   logic [PROD_W-1:0]        prod_ff [NUM_DIMS];
   logic [IDX_W-1:0]         coord_in [NUM_DIMS];

   // stage 3: response register
   logic                     rsp_valid_ff;
   logic                     rsp_last_ff;
   logic                     rsp_overrun_ff;
   logic [ADDR_W-1:0]        rsp_addr_ff;
   logic [IDX_W-1:0]         rsp_coord_ff [NUM_DIMS];

   logic rdy1;
   logic rdy2;
   logic rdy3;

   assign rdy3 = !rsp_valid_ff || rsp_tready;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;

   assign req_tready      = rdy1;
   assign req_acc         = req_tvalid && req_tready;
   assign req_dim         = req_tdata[1:0];
   assign req_position    = req_tdata[11:2];
   assign req_index_value = req_tdata[21:12];
   assign do_load         = req_acc && (req_tuser == siag_pkg::KIND_LOAD);
   assign do_restart      = req_acc && (req_tuser == siag_pkg::KIND_RESTART);
   assign do_next         = req_acc && (req_tuser == siag_pkg::KIND_NEXT);
   assign pos_ok          = (32'(req_position) < MAX_EXTENT);

   // csr block
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff   <= '0;
         extent_ff <= {NUM_DIMS{siag_pkg::EXT_REG_W'(1)}};
         stride_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            siag_pkg::CSR_RANK:     rank_ff      <= csr_wdata[siag_pkg::RANK_W-1:0];
            siag_pkg::CSR_EXTENT_0: extent_ff[0] <= csr_wdata[siag_pkg::EXT_REG_W-1:0];
            siag_pkg::CSR_EXTENT_1: extent_ff[1] <= csr_wdata[siag_pkg::EXT_REG_W-1:0];
            siag_pkg::CSR_EXTENT_2: extent_ff[2] <= csr_wdata[siag_pkg::EXT_REG_W-1:0];
            siag_pkg::CSR_STRIDE_0: stride_ff[0] <= csr_wdata;
            siag_pkg::CSR_STRIDE_1: stride_ff[1] <= csr_wdata;
            siag_pkg::CSR_STRIDE_2: stride_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   siag_odometer #(
      .MAX_EXTENT (MAX_EXTENT),
      .TABLE_DIMS (TABLE_DIMS)
   ) u_odometer (
      .clock   (clock),
      .reset   (reset),
      .step    (do_next),
      .restart (do_restart),
      .rank    (rank_ff),
      .extent  (extent_ff),
      .cnt_upd (cnt_upd),
      .status  (odo_status)
   );

   // remap tables, one per dimension below TABLE_DIMS
   for (genvar g = 0; g < NUM_DIMS; g++) begin : g_table
      if (g < TABLE_DIMS) begin : g_mem
         logic [IDX_W-1:0] mem [MAX_EXTENT];

         always_ff @(posedge clock) begin
            if (do_load && pos_ok && (32'(req_dim) == g)) begin
               mem[CW'(req_position)] <= req_index_value;
            end
            if (rdy1) begin
               rd_ff[g] <= mem[cnt_upd[g]];
            end
         end
      end else begin : g_none
         always_ff @(posedge clock) begin
            rd_ff[g] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (rdy1) begin
         s1_valid_ff <= do_next;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_status_ff <= odo_status;
      end
   end

   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         coord_in[d] = (s1_status_ff.in_use[d] && !s1_status_ff.overrun) ? rd_ff[d] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (rdy2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_last_ff    <= s1_status_ff.last;
         s2_overrun_ff <= s1_status_ff.overrun;
         for (int d = 0; d < NUM_DIMS; d++) begin
            coord_ff[d] <= coord_in[d];
            prod_ff[d]  <= PROD_W'(coord_in[d]) * PROD_W'(stride_ff[d]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy3) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         rsp_last_ff    <= s2_last_ff;
         rsp_overrun_ff <= s2_overrun_ff;
         rsp_addr_ff    <= ADDR_W'(prod_ff[0]) + ADDR_W'(prod_ff[1]) + ADDR_W'(prod_ff[2]);
         for (int d = 0; d < NUM_DIMS; d++) begin
            rsp_coord_ff[d] <= coord_ff[d];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_overrun_ff;
   assign rsp_tdata  = {6'b0, rsp_coord_ff[2], rsp_coord_ff[1], rsp_coord_ff[0], rsp_addr_ff};

   a_overrun_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[57:0] == '0 && !rsp_tlast)
      else $error("overrun response carries an address");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !rdy3 |=> s2_valid_ff && $stable(s2_last_ff) && $stable(s2_overrun_ff))
      else $error("product stage lost a response under stall");

   a_next_flows: assert property (@(posedge clock) disable iff (reset)
      do_next |=> s1_valid_ff)
      else $error("accepted next request did not enter the pipeline");

endmodule

// ===== tb/tb_strided_index_address_generator.sv =====
`timescale 1ns / 1ps
// tb_strided_index_address_generator: self-checking bench that walks the odometer over random views
// and compares every response with a cycle-free prediction of addresses, coordinates and flags
// depends on siag_pkg and strided_index_address_generator

module tb_strided_index_address_generator;

   localparam int TOTAL_REQUESTS  = 950;
   localparam int QUIET_AFTER     = 800;
   localparam int SETTLE_CYCLES   = 8;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int REPORT_LIMIT    = 10;

   localparam int NUM_DIMS    = siag_pkg::NUM_DIMS;
   localparam int MAX_EXTENT  = siag_pkg::DEF_MAX_EXTENT;
   localparam int KIND_W      = siag_pkg::KIND_W;
   localparam int DIM_W       = siag_pkg::DIM_W;
   localparam int POS_W       = siag_pkg::POS_W;
   localparam int IDX_W       = siag_pkg::IDX_W;
   localparam int ADDR_W      = siag_pkg::ADDR_W;
   localparam int RANK_W      = siag_pkg::RANK_W;
   localparam int EXT_REG_W   = siag_pkg::EXT_REG_W;
   localparam int STRIDE_W    = siag_pkg::STRIDE_W;
   localparam int CSR_IDX_W   = siag_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = siag_pkg::CSR_DATA_W;
   localparam int REQ_TDATA_W = siag_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = siag_pkg::RSP_TDATA_W;

   localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
   localparam logic [DIM_W-1:0]     DIM_UNUSED  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE   = 3'd7;

   typedef struct packed {
      logic                           overrun;
      logic                           last;
      logic [NUM_DIMS-1:0][IDX_W-1:0] coord;
      logic [ADDR_W-1:0]              address;
   } gather_result_type;

   typedef logic [NUM_DIMS-1:0][POS_W-1:0] odometer_type;

   class gather_walk;
      logic [RANK_W-1:0]    rank;
      logic [EXT_REG_W-1:0] extent [NUM_DIMS];
      logic [STRIDE_W-1:0]  stride [NUM_DIMS];
      logic [IDX_W-1:0]     remap  [NUM_DIMS][MAX_EXTENT];
      bit                   loaded [NUM_DIMS][MAX_EXTENT];
      odometer_type         counters;
      bit                   started;
      gather_result_type    due_results [$];
      int                   mismatches;

      function new();
         rank       = '0;
         counters   = '0;
         started    = 1'b0;
         mismatches = 0;
         for (int d = 0; d < NUM_DIMS; d++) begin
            extent[d] = 1;
            stride[d] = '0;
            for (int p = 0; p < MAX_EXTENT; p++) begin
               loaded[d][p] = 1'b0;
            end
         end
      endfunction

      function int unsigned span(int d);
         int unsigned e;
         e = extent[d];
         if (e == 0) e = 1;
         if (e > MAX_EXTENT) e = MAX_EXTENT;
         return e;
      endfunction

      // returns 0 when the walk is already at its final position
      function bit advance(input odometer_type cur, input bit was_started,
                           output odometer_type nxt);
         int k;
         nxt = cur;
         if (!was_started) return 1'b1;
         k = int'(rank) - 1;
         while (k >= 0 && cur[k] + 1 >= span(k)) k--;
         if (k < 0) return 1'b0;
         nxt[k] = cur[k] + 1'b1;
         for (int d = k + 1; d < rank; d++) nxt[d] = '0;
         return 1'b1;
      endfunction

      // table entry that the coming next request would read without it ever being loaded
      function bit unloaded_entry(output int unsigned dim_out, output int unsigned pos_out);
         odometer_type nxt;
         dim_out = 0;
         pos_out = 0;
         if (!advance(counters, started, nxt)) return 1'b0;
         for (int d = 0; d < rank; d++) begin
            if (!loaded[d][nxt[d]]) begin
               dim_out = d;
               pos_out = nxt[d];
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            siag_pkg::CSR_RANK:     rank      = data[RANK_W-1:0];
            siag_pkg::CSR_EXTENT_0: extent[0] = data[EXT_REG_W-1:0];
            siag_pkg::CSR_EXTENT_1: extent[1] = data[EXT_REG_W-1:0];
            siag_pkg::CSR_EXTENT_2: extent[2] = data[EXT_REG_W-1:0];
            siag_pkg::CSR_STRIDE_0: stride[0] = data;
            siag_pkg::CSR_STRIDE_1: stride[1] = data;
            siag_pkg::CSR_STRIDE_2: stride[2] = data;
            default: ;
         endcase
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [DIM_W-1:0] dim,
                                 logic [POS_W-1:0] pos, logic [IDX_W-1:0] value);
         gather_result_type r;
         odometer_type      nxt;
         r = '0;
         case (kind)
            siag_pkg::KIND_LOAD: begin
               if (dim < NUM_DIMS) begin
                  remap[dim][pos]  = value;
                  loaded[dim][pos] = 1'b1;
               end
            end
            siag_pkg::KIND_RESTART: begin
               counters = '0;
               started  = 1'b0;
            end
            siag_pkg::KIND_NEXT: begin
               if (!advance(counters, started, nxt)) begin
                  r.overrun = 1'b1;
               end else begin
                  counters = nxt;
                  started  = 1'b1;
                  r.last   = 1'b1;
                  for (int d = 0; d < rank; d++) begin
                     r.coord[d] = remap[d][counters[d]];
                     r.address  = r.address + r.coord[d] * stride[d];
                     if (counters[d] + 1 < span(d)) r.last = 1'b0;
                  end
               end
               due_results.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] data, logic last, logic overrun);
         gather_result_type want;
         gather_result_type got;
         bit                bad;
         got.address = data[ADDR_W-1:0];
         for (int d = 0; d < NUM_DIMS; d++) got.coord[d] = data[ADDR_W + d*IDX_W +: IDX_W];
         got.last    = last;
         got.overrun = overrun;
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: response with nothing due: addr %h coords %h %h %h last %b ovr %b",
                        $realtime, got.address, got.coord[0], got.coord[1], got.coord[2],
                        got.last, got.overrun);
            return;
         end
         want = due_results.pop_front();
         bad  = (got.address !== want.address) || (got.coord[0] !== want.coord[0]) ||
                (got.coord[1] !== want.coord[1]) || (got.coord[2] !== want.coord[2]) ||
                (got.last !== want.last) || (got.overrun !== want.overrun);
         if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: expected addr %h coords %h %h %h last %b ovr %b", $realtime,
                        want.address, want.coord[0], want.coord[1], want.coord[2],
                        want.last, want.overrun);
               $display("%0t:      got addr %h coords %h %h %h last %b ovr %b", $realtime,
                        got.address, got.coord[0], got.coord[1], got.coord[2],
                        got.last, got.overrun);
            end
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // dim [1:0], position [11:2], index_value [21:12], zero fill
   logic [REQ_TDATA_W-1:0] req_tdata;
   // kind
   logic [KIND_W-1:0]      req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // address [27:0], coord_0 [37:28], coord_1 [47:38], coord_2 [57:48], zero fill
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   // overrun
   logic                   rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   gather_walk walk;
   int         requests_sent = 0;
   int         idle_cycles   = 0;
   int         gap_odds      = 3;
   bit         gaps_on       = 1'b1;

   strided_index_address_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            walk.note_request(req_tuser, req_tdata[DIM_W-1:0], req_tdata[DIM_W +: POS_W],
                              req_tdata[DIM_W+POS_W +: IDX_W]);
         if (rsp_tvalid && rsp_tready)
            walk.check_response(rsp_tdata, rsp_tlast, rsp_tuser);
         if (csr_valid && csr_ready)
            walk.write_register(csr_index, csr_wdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // response side back-pressure
   initial begin
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_tready = 1'b1;
         repeat ($urandom_range(1, 24)) @(negedge clock);
      end
   end

   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [DIM_W-1:0] dim,
                               input logic [POS_W-1:0] pos, input logic [IDX_W-1:0] value);
      if (gaps_on && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tuser  = kind;
      req_tdata  = REQ_TDATA_W'({value, pos, dim});
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (kind == siag_pkg::KIND_NEXT || kind == siag_pkg::KIND_RESTART ||
          (kind == siag_pkg::KIND_LOAD && dim < NUM_DIMS))
         requests_sent++;
      if (requests_sent >= QUIET_AFTER) gaps_on = 1'b0;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_index = idx;
      csr_wdata = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_registers(input logic [RANK_W-1:0] r, input logic [EXT_REG_W-1:0] e0,
                                input logic [EXT_REG_W-1:0] e1, input logic [EXT_REG_W-1:0] e2,
                                input logic [STRIDE_W-1:0] s0, input logic [STRIDE_W-1:0] s1,
                                input logic [STRIDE_W-1:0] s2);
      write_csr(siag_pkg::CSR_RANK, CSR_DATA_W'(r));
      write_csr(siag_pkg::CSR_EXTENT_0, CSR_DATA_W'(e0));
      write_csr(siag_pkg::CSR_EXTENT_1, CSR_DATA_W'(e1));
      write_csr(siag_pkg::CSR_EXTENT_2, CSR_DATA_W'(e2));
      write_csr(siag_pkg::CSR_STRIDE_0, s0);
      write_csr(siag_pkg::CSR_STRIDE_1, s1);
      write_csr(siag_pkg::CSR_STRIDE_2, s2);
   endtask

   // hold requests until every response is back, then let loads and restarts settle
   task automatic drain();
      req_tvalid = 1'b0;
      while (walk.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // loads whatever the coming position reads, then steps
   task automatic issue_next();
      int unsigned d;
      int unsigned p;
      while (walk.unloaded_entry(d, p))
         send_request(siag_pkg::KIND_LOAD, DIM_W'(d), POS_W'(p),
                      IDX_W'($urandom_range(0, 1023)));
      send_request(siag_pkg::KIND_NEXT, DIM_W'($urandom_range(0, 3)), POS_W'($urandom),
                   IDX_W'($urandom));
   endtask

   function automatic logic [EXT_REG_W-1:0] pick_extent();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return EXT_REG_W'($urandom_range(0, 5));
      if (pick < 80) return EXT_REG_W'(MAX_EXTENT);
      if (pick < 86) return '1;
      return EXT_REG_W'($urandom_range(6, 2047));
   endfunction

   function automatic logic [STRIDE_W-1:0] pick_stride();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return STRIDE_W'($urandom);
   endfunction

   task automatic random_request();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         issue_next();
      else if (pick < 78)
         send_request(siag_pkg::KIND_RESTART, DIM_W'($urandom), POS_W'($urandom),
                      IDX_W'($urandom));
      else if (pick < 92)
         send_request(siag_pkg::KIND_LOAD, DIM_W'($urandom_range(0, 2)), POS_W'($urandom),
                      IDX_W'($urandom));
      else if (pick < 96)
         send_request(siag_pkg::KIND_LOAD, DIM_UNUSED, POS_W'($urandom), IDX_W'($urandom));
      else
         send_request(KIND_UNUSED, DIM_W'($urandom), POS_W'($urandom), IDX_W'($urandom));
   endtask

   task automatic run_directed();
      // scalar view straight out of reset, then overrun, ignored and bad requests
      send_request(siag_pkg::KIND_NEXT, '0, '0, '0);
      send_request(siag_pkg::KIND_NEXT, '1, '1, '1);
      send_request(KIND_UNUSED, DIM_W'(1), POS_W'(512), IDX_W'(341));
      send_request(siag_pkg::KIND_LOAD, DIM_UNUSED, '1, '1);
      send_request(siag_pkg::KIND_LOAD, DIM_W'(2), '1, '1);
      send_request(siag_pkg::KIND_LOAD, DIM_W'(0), '0, '0);
      send_request(siag_pkg::KIND_RESTART, '0, '0, '0);
      send_request(siag_pkg::KIND_NEXT, '0, '0, '0);
      drain();
      // full rank, zero extent in the middle, largest strides, walk past the end
      write_csr(CSR_SPARE, '1);
      set_registers(RANK_W'(3), EXT_REG_W'(2), '0, EXT_REG_W'(2), '1, '1, '1);
      send_request(siag_pkg::KIND_RESTART, '0, '0, '0);
      repeat (5) issue_next();
   endtask

   task automatic run_random();
      while (requests_sent < TOTAL_REQUESTS) begin
         drain();
         gap_odds = $urandom_range(0, 6);
         set_registers(RANK_W'($urandom_range(0, 3)), pick_extent(), pick_extent(),
                       pick_extent(), pick_stride(), pick_stride(), pick_stride());
         if ($urandom_range(0, 3) != 0)
            send_request(siag_pkg::KIND_RESTART, '0, '0, '0);
         repeat ($urandom_range(10, 60)) random_request();
      end
   endtask

   initial begin
      walk       = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = siag_pkg::KIND_LOAD;
      csr_valid  = 1'b0;
      csr_index  = siag_pkg::CSR_RANK;
      csr_wdata  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      run_random();
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (walk.outstanding() != 0)
         $display("%0d expected responses never arrived", walk.outstanding());
      if (walk.mismatches == 0 && walk.outstanding() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
